// ===== sv/sukt_pkg.sv =====
// types and constants shared by the sorted unique key table
package sukt_pkg;

	localparam int KEY_W = 32;
	localparam int FIELD_W = 7;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_DELETE = 2'd1,
		CMD_FIND   = 2'd2
	} sukt_cmd_t;

	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_FULL    = 2'd1,
		STATUS_EXISTS  = 2'd2,
		STATUS_MISSING = 2'd3
	} sukt_status_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_COMPARE,
		PH_UPDATE
	} sukt_phase_t;

	typedef struct packed {
		sukt_cmd_t                 command;
		logic signed [KEY_W-1:0]   key;
	} sukt_req_t;

	typedef struct packed {
		sukt_status_t              status;
		logic                      found;
		logic [FIELD_W-1:0]        position;
		logic [FIELD_W-1:0]        entry_count;
	} sukt_rsp_t;

	// broadcast to every cell of the chain
	typedef struct packed {
		logic cmp;
		logic ins;
		logic del;
	} sukt_cell_ctrl_t;

endpackage

// ===== sv/sorted_unique_key_table.sv =====
// top level of the sorted unique key table
//
// holds up to MAX_ENTRIES distinct signed keys in ascending order in a row of
// cells, key 0 in the first cell. a command is taken when start is high and
// busy is low; in the next cycle every cell compares its key with the command
// key, and in the cycle after that the table shifts one place (right for an
// insert, left for a delete) and the result is latched. done is high for
// exactly one cycle with the result on rsp; the result cannot be held off, so
// a receiver must take it in that cycle. busy is high only in the compare
// cycle, so a new command may be given in the same cycle in which the
// previous one updates the table, the compare flags being registered ahead
// of the shift. insert reports full before it checks for a duplicate.
// command code 3 does nothing and reports success with found and position
// clear. position and entry_count carry the low seven bits of the index and
// count. no clearing pass is needed after reset: cells past the count never
// take part in a compare.
module sorted_unique_key_table import sukt_pkg::*; #(
	parameter int MAX_ENTRIES = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  sukt_req_t req,
	output logic      done,
	output sukt_rsp_t rsp
);

	localparam int CW = $clog2(MAX_ENTRIES + 1);

	sukt_phase_t             state_q, state_d;
	sukt_req_t               req_q;
	logic [CW-1:0]           count_q, count_d;
	sukt_rsp_t               rsp_q, rsp_d;
	logic                    done_q;
	sukt_cell_ctrl_t         ctrl;

	logic signed [KEY_W-1:0] key_vec [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0]  lt_vec;
	logic [MAX_ENTRIES-1:0]  eq_vec;
	logic [MAX_ENTRIES-1:0]  bnd_vec;

	logic                    full;
	logic                    hit;
	logic [CW-1:0]           idx;
	logic                    accept;

	assign accept = start && !busy;

	// the chain of cells
	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		logic                    live;
		logic                    left_lt;
		logic signed [KEY_W-1:0] left_key;
		logic signed [KEY_W-1:0] right_key;

		assign live = CW'(i) < count_q;

		if (i == 0) begin : g_first
			assign left_lt  = 1'b1;
			assign left_key = req_q.key;
			assign bnd_vec[i] = !lt_vec[i];
		end else begin : g_rest
			assign left_lt  = lt_vec[i-1];
			assign left_key = key_vec[i-1];
			assign bnd_vec[i] = !lt_vec[i] && lt_vec[i-1];
		end

		if (i == MAX_ENTRIES - 1) begin : g_last
			assign right_key = key_vec[i];
		end else begin : g_mid
			assign right_key = key_vec[i+1];
		end

		sukt_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.live      (live),
			.probe     (req_q.key),
			.left_lt   (left_lt),
			.left_key  (left_key),
			.right_key (right_key),
			.key_q     (key_vec[i]),
			.lt_q      (lt_vec[i]),
			.eq_q      (eq_vec[i])
		);
	end

	// sorted index: the one cell where the smaller-than run ends, or MAX_ENTRIES if it runs to the end
	always_comb begin
		idx = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (bnd_vec[i]) begin
				idx = idx | CW'(i);
			end
		end
		if (lt_vec[MAX_ENTRIES-1]) begin
			idx = CW'(MAX_ENTRIES);
		end
	end

	assign hit  = |eq_vec;
	assign full = count_q == CW'(MAX_ENTRIES);

	// result and new count, used in the update cycle
	always_comb begin
		rsp_d.status      = STATUS_OK;
		rsp_d.found       = 1'b0;
		rsp_d.position    = '0;
		count_d           = count_q;
		unique case (req_q.command)
			CMD_INSERT: begin
				priority if (full) begin
					rsp_d.status = STATUS_FULL;
				end else if (hit) begin
					rsp_d.status   = STATUS_EXISTS;
					rsp_d.found    = 1'b1;
					rsp_d.position = FIELD_W'(idx);
				end else begin
					rsp_d.position = FIELD_W'(idx);
					count_d        = count_q + CW'(1);
				end
			end
			CMD_DELETE: begin
				if (hit) begin
					rsp_d.found    = 1'b1;
					rsp_d.position = FIELD_W'(idx);
					count_d        = count_q - CW'(1);
				end else begin
					rsp_d.status = STATUS_MISSING;
				end
			end
			CMD_FIND: begin
				if (hit) begin
					rsp_d.found    = 1'b1;
					rsp_d.position = FIELD_W'(idx);
				end else begin
					rsp_d.status = STATUS_MISSING;
				end
			end
			default: begin
			end
		endcase
		rsp_d.entry_count = FIELD_W'(count_d);
	end

	// sequencer
	always_comb begin
		state_d  = state_q;
		busy     = 1'b0;
		ctrl.cmp = 1'b0;
		ctrl.ins = 1'b0;
		ctrl.del = 1'b0;
		unique case (state_q)
			PH_IDLE: begin
				if (start) begin
					state_d = PH_COMPARE;
				end
			end
			PH_COMPARE: begin
				busy     = 1'b1;
				ctrl.cmp = 1'b1;
				state_d  = PH_UPDATE;
			end
			PH_UPDATE: begin
				ctrl.ins = (req_q.command == CMD_INSERT) && !full && !hit;
				ctrl.del = (req_q.command == CMD_DELETE) && hit;
				state_d  = start ? PH_COMPARE : PH_IDLE;
			end
			default: begin
				state_d = PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PH_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= state_q == PH_UPDATE;
			if (state_q == PH_UPDATE) begin
				count_q <= count_d;
			end
		end
	end

	// command and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (state_q == PH_UPDATE) begin
			rsp_q <= rsp_d;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	// checks
	a_done_after_update: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q) == PH_UPDATE)
		else $error("result strobe without an update cycle");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ENTRIES))
		else $error("entry count beyond capacity");

	a_count_only_on_update: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != PH_UPDATE |=> $stable(count_q))
		else $error("entry count changed outside an update");

	a_single_match: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == PH_UPDATE |-> $onehot0(eq_vec))
		else $error("key held twice in the table");

	a_single_boundary: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == PH_UPDATE |-> $onehot0(bnd_vec))
		else $error("table order broken");

endmodule

// ===== sv/sukt_cell.sv =====
// one cell of the sorted key chain: holds a key, compares it, shifts with its neighbours
module sukt_cell import sukt_pkg::*; (
	input  logic                    clk,
	input  sukt_cell_ctrl_t         ctrl,
	input  logic                    live,
	input  logic signed [KEY_W-1:0] probe,
	input  logic                    left_lt,
	input  logic signed [KEY_W-1:0] left_key,
	input  logic signed [KEY_W-1:0] right_key,
	output logic signed [KEY_W-1:0] key_q,
	output logic                    lt_q,
	output logic                    eq_q
);

	// flags only meaningful after a compare cycle
	always_ff @(posedge clk) begin
		if (ctrl.cmp) begin
			lt_q <= live && (key_q < probe);
			eq_q <= live && (key_q == probe);
		end
	end

	// cells at or past the insertion point move right, or left on delete
	always_ff @(posedge clk) begin
		if (ctrl.ins && !lt_q) begin
			key_q <= left_lt ? probe : left_key;
		end else if (ctrl.del && !lt_q) begin
			key_q <= right_key;
		end
	end

endmodule
